[rtl/smt_pkg.sv]
// Shared types, constants and helper functions for the softmax with temperature block.
// Used by smt_div and softmax_with_temperature; depends on nothing else.
package smt_pkg;

    localparam int MAX_LEN         = 64;
    localparam int LOGIT_FRAC_BITS = 16;
    localparam int LOGIT_W         = 8 + LOGIT_FRAC_BITS;
    localparam int ADDR_W          = $clog2(MAX_LEN);
    localparam int CNT_W           = $clog2(MAX_LEN + 1);
    localparam int EXP_W           = 17;
    localparam int PROB_W          = 17;
    localparam int POS_W           = 6;
    localparam int SUM_W           = EXP_W + ADDR_W;
    localparam int TEMP_W          = 16;
    localparam int Z_W             = 32;
    localparam int LOG2E_W         = 17;
    localparam int PROD_W          = Z_W + LOG2E_W;
    localparam int FRAC_TAB_W      = 12;
    localparam int MUL_W           = EXP_W + FRAC_TAB_W;
    localparam int DIV_NUM_W       = 34;
    localparam int DIV_DEN_W       = 23;
    localparam int DIV_CNT_W       = $clog2(DIV_NUM_W);
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 16;

    localparam logic [LOG2E_W-1:0] LOG2E_Q16 = 17'd94548;
    localparam logic [TEMP_W-1:0] TEMP_RESET = 16'd256;
    localparam logic signed [LOGIT_W-1:0] QMIN = {1'b1, {(LOGIT_W-1){1'b0}}};
    localparam logic signed [LOGIT_W-1:0] QMAX = {1'b0, {(LOGIT_W-1){1'b1}}};

    localparam logic [CFG_IDX_W-1:0] REG_TEMPERATURE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_FORMAT = 1'd1;

    typedef struct packed {
        logic [31:0] logit_bits;
        logic        last_element;
    } in_item_t;

    typedef struct packed {
        logic [PROB_W-1:0] probability;
        logic [POS_W-1:0]  position;
        logic              final_result;
        logic              truncated;
    } out_item_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic                 busy;
        logic [DIV_NUM_W-1:0] quo;
    } div_rsp_t;

    typedef enum logic [3:0] {
        S_LOAD,
        S_EXP_RD,
        S_EXP_START,
        S_EXP_DIV,
        S_EXP_MUL,
        S_EXP_TAB,
        S_EXP_WR,
        S_NORM_RD,
        S_NORM_START,
        S_NORM_DIV,
        S_OUT
    } state_t;

    function automatic logic [EXP_W-1:0] pow2_frac(input logic [4:0] k);
        logic [EXP_W-1:0] v;
        unique case (k)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            5'd16:   v = 17'd32768;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [LOGIT_W-1:0] to_fixed(input logic [31:0] bits);
        logic        neg;
        logic [7:0]  ex;
        logic [31:0] sig;
        logic [31:0] mag;
        int          sh;
        neg = bits[31];
        ex  = bits[30:23];
        sig = {8'd0, 1'b1, bits[22:0]};
        sh  = int'(ex) - 150 + LOGIT_FRAC_BITS;
        if (sh >= 0)
        begin
            mag = sig << sh;
        end
        else if (-sh >= 32)
        begin
            mag = 32'd0;
        end
        else
        begin
            mag = sig >> (-sh);
        end
        if (ex == 8'd0)
        begin
            return '0;
        end
        else if (ex == 8'd255 || int'(ex) - 127 >= 7)
        begin
            return neg ? QMIN : QMAX;
        end
        else
        begin
            return neg ? LOGIT_W'(-mag) : LOGIT_W'(mag);
        end
    endfunction

endpackage

[rtl/smt_div.sv]
// Restoring divider that produces one quotient bit per cycle.
// Depends on smt_pkg for operand widths and the request and response structs.
module smt_div (
    input  logic            clk,
    input  logic            rst_n,
    input  smt_pkg::div_req_t req,
    output smt_pkg::div_rsp_t rsp
);
    import smt_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W:0]   trial;

    assign trial = {rem_reg, quo_reg[DIV_NUM_W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.num;
            den_reg <= req.den;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_reg <= DIV_DEN_W'(trial - {1'b0, den_reg});
                quo_reg <= {quo_reg[DIV_NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[DIV_DEN_W-1:0];
                quo_reg <= {quo_reg[DIV_NUM_W-2:0], 1'b0};
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.busy = busy_reg;
    assign rsp.quo  = quo_reg;

endmodule

[rtl/softmax_with_temperature.sv]
// Top level of the softmax with temperature block: load, exponent and normalize passes.
// Depends on smt_pkg and instantiates smt_div.
//
// Logits arrive on the in channel, one per transfer, as fp32 or bf16 bit patterns.
// Each accepted logit is converted to signed Q8.16 and written to the logit memory
// while the running maximum is tracked; a transfer without last_element produces
// no output. The transfer with last_element starts two passes over the stored
// elements. The exponent pass runs each element through the shared divider, which
// is skipped with temperature zero. The normalize pass also runs each element
// through the divider and is further held by any output stall.
// Probabilities leave on the out channel in element order, the last one flagged by
// final_result. While the passes run, in_ready is low. A stalled receiver holds the
// block in its output state with the transfer unchanged until it is taken. After the
// final transfer the block is empty and accepts the next vector. Elements beyond 64
// are dropped and flag truncated on every output of that vector. Reset empties the
// vector and restores temperature 1.0 and fp32 format; no memory clearing is needed.
// Configuration writes are always accepted and must be made while the block is idle.
module softmax_with_temperature (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  smt_pkg::in_item_t                  in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output smt_pkg::out_item_t                 out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [smt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [smt_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import smt_pkg::*;

    state_t state_reg;
    state_t state_next;

    logic [TEMP_W-1:0]          temp_reg;
    logic                       fmt_reg;
    logic signed [LOGIT_W-1:0]  max_reg;
    logic [CNT_W-1:0]           count_reg;
    logic [SUM_W-1:0]           sum_reg;
    logic                       ovf_reg;
    logic [ADDR_W-1:0]          idx_reg;
    logic [Z_W-1:0]             z_reg;
    logic [PROD_W-1:0]          prod_reg;
    logic [MUL_W-1:0]           mult_reg;
    logic [3:0]                 k_reg;
    logic [4:0]                 n_reg;
    logic                       big_reg;
    out_item_t                  out_reg;

    logic signed [LOGIT_W-1:0]  logit_mem [MAX_LEN];
    logic [EXP_W-1:0]           exp_mem [MAX_LEN];
    logic signed [LOGIT_W-1:0]  logit_rdata_reg;
    logic [EXP_W-1:0]           exp_rdata_reg;

    logic                       in_fire;
    logic                       out_fire;
    logic [31:0]                bits;
    logic signed [LOGIT_W-1:0]  q;
    logic [LOGIT_W-1:0]         d;
    logic                       idx_last;
    logic [16:0]                n_full;
    logic [EXP_W-1:0]           tab_k;
    logic [EXP_W-1:0]           tab_diff;
    logic [EXP_W-1:0]           v;
    logic [EXP_W-1:0]           e;
    logic [DIV_NUM_W-1:0]       norm_num;
    div_req_t                   div_req;
    div_rsp_t                   div_rsp;

    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;
    assign cfg_ready = 1'b1;
    assign out_data  = out_reg;

    assign bits     = fmt_reg ? {in_data.logit_bits[15:0], 16'd0} : in_data.logit_bits;
    assign q        = to_fixed(bits);
    assign d        = LOGIT_W'(max_reg - logit_rdata_reg);
    assign idx_last = ({1'b0, idx_reg} == CNT_W'(count_reg - 1'b1));
    assign n_full   = prod_reg[PROD_W-1:LOGIT_FRAC_BITS+16];
    assign tab_k    = pow2_frac({1'b0, prod_reg[LOGIT_FRAC_BITS+15:LOGIT_FRAC_BITS+12]});
    assign tab_diff = tab_k - pow2_frac(5'(prod_reg[LOGIT_FRAC_BITS+15:LOGIT_FRAC_BITS+12])
                                        + 5'd1);
    assign v        = pow2_frac({1'b0, k_reg}) - EXP_W'(mult_reg >> FRAC_TAB_W);
    assign e        = big_reg ? '0 : (v >> n_reg);
    assign norm_num = {exp_rdata_reg, 16'd0} + DIV_NUM_W'(sum_reg >> 1);

    smt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_fire && in_data.last_element)
                begin
                    state_next = S_EXP_RD;
                end
            end
            S_EXP_RD:     state_next = S_EXP_START;
            S_EXP_START:  state_next = (temp_reg == '0) ? S_EXP_MUL : S_EXP_DIV;
            S_EXP_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_EXP_MUL;
                end
            end
            S_EXP_MUL:    state_next = S_EXP_TAB;
            S_EXP_TAB:    state_next = S_EXP_WR;
            S_EXP_WR:     state_next = idx_last ? S_NORM_RD : S_EXP_RD;
            S_NORM_RD:    state_next = S_NORM_START;
            S_NORM_START: state_next = (sum_reg == '0) ? S_OUT : S_NORM_DIV;
            S_NORM_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_fire)
                begin
                    state_next = out_reg.final_result ? S_LOAD : S_NORM_RD;
                end
            end
            default:      state_next = S_LOAD;
        endcase
    end

    always_comb
    begin
        in_ready      = (state_reg == S_LOAD);
        out_valid     = (state_reg == S_OUT);
        div_req.start = ((state_reg == S_EXP_START) && (temp_reg != '0))
                        || ((state_reg == S_NORM_START) && (sum_reg != '0));
        if (state_reg == S_NORM_START)
        begin
            div_req.num = norm_num;
            div_req.den = DIV_DEN_W'(sum_reg);
        end
        else
        begin
            div_req.num = DIV_NUM_W'({d, 8'd0});
            div_req.den = DIV_DEN_W'(temp_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            temp_reg  <= TEMP_RESET;
            fmt_reg   <= 1'b0;
            max_reg   <= QMIN;
            count_reg <= '0;
            sum_reg   <= '0;
            ovf_reg   <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_TEMPERATURE)
                begin
                    temp_reg <= cfg_data;
                end
                else if (cfg_index == REG_INPUT_FORMAT)
                begin
                    fmt_reg <= cfg_data[0];
                end
            end
            if (in_fire)
            begin
                if (count_reg < CNT_W'(MAX_LEN))
                begin
                    count_reg <= count_reg + 1'b1;
                    if (q > max_reg)
                    begin
                        max_reg <= q;
                    end
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
                if (in_data.last_element)
                begin
                    sum_reg <= '0;
                    idx_reg <= '0;
                end
            end
            if (state_reg == S_EXP_WR)
            begin
                sum_reg <= sum_reg + SUM_W'(e);
                idx_reg <= idx_last ? '0 : idx_reg + 1'b1;
            end
            if (out_fire)
            begin
                idx_reg <= out_reg.final_result ? '0 : idx_reg + 1'b1;
                if (out_reg.final_result)
                begin
                    max_reg   <= QMIN;
                    count_reg <= '0;
                    sum_reg   <= '0;
                    ovf_reg   <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && (count_reg < CNT_W'(MAX_LEN)))
        begin
            logit_mem[count_reg[ADDR_W-1:0]] <= q;
        end
        if (state_reg == S_EXP_RD)
        begin
            logit_rdata_reg <= logit_mem[idx_reg];
        end
        if (state_reg == S_EXP_WR)
        begin
            exp_mem[idx_reg] <= e;
        end
        if (state_reg == S_NORM_RD)
        begin
            exp_rdata_reg <= exp_mem[idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_EXP_START) && (temp_reg == '0))
        begin
            z_reg <= Z_W'(d);
        end
        else if ((state_reg == S_EXP_DIV) && div_rsp.done)
        begin
            z_reg <= div_rsp.quo[Z_W-1:0];
        end
        if (state_reg == S_EXP_MUL)
        begin
            prod_reg <= PROD_W'(z_reg) * PROD_W'(LOG2E_Q16);
        end
        if (state_reg == S_EXP_TAB)
        begin
            mult_reg <= MUL_W'(tab_diff) * MUL_W'(prod_reg[LOGIT_FRAC_BITS+11:LOGIT_FRAC_BITS]);
            k_reg    <= prod_reg[LOGIT_FRAC_BITS+15:LOGIT_FRAC_BITS+12];
            n_reg    <= n_full[4:0];
            big_reg  <= (n_full >= 17'd17);
        end
        if (state_reg == S_NORM_START)
        begin
            out_reg.probability  <= '0;
            out_reg.position     <= POS_W'(idx_reg);
            out_reg.final_result <= idx_last;
            out_reg.truncated    <= ovf_reg;
        end
        else if ((state_reg == S_NORM_DIV) && div_rsp.done)
        begin
            out_reg.probability <= div_rsp.quo[PROB_W-1:0];
        end
    end

`ifndef ASSERT_OFF
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !in_ready)
        else $error("input accepted while an output is pending");
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_W'(MAX_LEN))
        else $error("element count exceeds the store depth");
    assert property (@(posedge clk) disable iff (!rst_n) div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && out_data.final_result |=> in_ready && (count_reg == '0))
        else $error("vector not cleared after its final transfer");
`endif

endmodule
